// ----- design/keyframe_linear_sampler_defines.svh -----
// assertion macros for the checker file
`ifndef KEYFRAME_LINEAR_SAMPLER_DEFINES_SVH
`define KEYFRAME_LINEAR_SAMPLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/kls_pkg.sv -----
package kls_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	// fraction 0..65536 needs 17 bits
	localparam int Q_W    = FRAC_W + 1;
	// difference of two words, signed
	localparam int DIFF_W = WORD_W + 1;
	// product of difference and fraction plus rounding headroom
	localparam int ACC_W  = DIFF_W + Q_W + 1;
	localparam int CFG_W  = 7;
	localparam int SLOT_W = 6;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic [1:0] WHERE_FIRST = 2'd0;
	localparam logic [1:0] WHERE_SEG   = 2'd1;
	localparam logic [1:0] WHERE_LAST  = 2'd2;

	// component 0 is x, 1 is y, 2 is z
	typedef logic [2:0][WORD_W-1:0] vec_t;

endpackage

// ----- design/kls_frac_div.sv -----
// restoring divider, one quotient bit per cycle, msb first
// quot = floor((num << 16) / den), num <= den assumed, den == 0 gives 0
module kls_frac_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [kls_pkg::WORD_W-1:0]  num,
	input  logic [kls_pkg::WORD_W-1:0]  den,
	output logic                        done,
	output logic [kls_pkg::Q_W-1:0]     quot
);

	localparam logic [4:0] LAST_STEP = 5'(kls_pkg::Q_W - 1);

	logic [kls_pkg::WORD_W:0]   rem_q;
	logic [kls_pkg::WORD_W-1:0] den_q;
	logic                       den_nz_q;
	logic [kls_pkg::Q_W-1:0]    quot_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic                       take;
	logic [kls_pkg::WORD_W:0]   rem_sub;
	logic [kls_pkg::WORD_W:0]   rem_nxt;

	always_comb begin
		rem_sub = rem_q - {1'b0, den_q};
		take    = den_nz_q && (rem_q >= {1'b0, den_q});
		rem_nxt = take ? rem_sub : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= {1'b0, num};
			den_q    <= den;
			den_nz_q <= (den != '0);
		end else if (busy_q) begin
			// remainder stays below den, so the top bit shifts out clean
			rem_q  <= {rem_nxt[kls_pkg::WORD_W-1:0], 1'b0};
			quot_q <= {quot_q[kls_pkg::Q_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- design/keyframe_linear_sampler.sv -----
// channel | direction | handshake             | beat carries
// --------+-----------+-----------------------+------------------------------------------
// in      | input     | in_valid / in_ready   | action, key_slot, key_time, key_x/y/z,
//         |           |                       | sample_time
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (keys_in_use)
// out     | output    | out_valid / out_ready | out_x/y/z, where_found, segment_start
//
// a keyframe write leaves the block idle, so in_ready stays high for the next beat
// a sample walks the time table one key per cycle through a single read port;
//   a first or last key hold goes straight to the output, while a segment reads both
//   end values, runs the serial divider, then a shift-and-add on the three components
// in_ready is low while a sample is in flight; an unclaimed result only stalls the
//   next sample at its last step; cfg is always ready
// arst_n clears control state only; the key tables hold nothing until written
module keyframe_linear_sampler #(
	parameter int KEY_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [kls_pkg::SLOT_W-1:0]         key_slot,
	input  logic [kls_pkg::WORD_W-1:0]         key_time,
	input  logic signed [kls_pkg::WORD_W-1:0]  key_x,
	input  logic signed [kls_pkg::WORD_W-1:0]  key_y,
	input  logic signed [kls_pkg::WORD_W-1:0]  key_z,
	input  logic [kls_pkg::WORD_W-1:0]         sample_time,
	// config channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kls_pkg::CFG_W-1:0]          cfg_data,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [kls_pkg::WORD_W-1:0]  out_x,
	output logic signed [kls_pkg::WORD_W-1:0]  out_y,
	output logic signed [kls_pkg::WORD_W-1:0]  out_z,
	output logic [1:0]                         where_found,
	output logic [kls_pkg::SLOT_W-1:0]         segment_start
);

	localparam int AW = $clog2(KEY_DEPTH);
	localparam int NW = $clog2(KEY_DEPTH + 1);
	localparam int W  = kls_pkg::WORD_W;
	localparam int DW = kls_pkg::DIFF_W;
	localparam int CW = kls_pkg::ACC_W;

	localparam logic [4:0] MUL_LAST = 5'(kls_pkg::Q_W - 1);

	// sequencer codes
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_FIRST    = 4'd1;
	localparam logic [3:0] S_WALK     = 4'd2;
	localparam logic [3:0] S_VA       = 4'd3;
	localparam logic [3:0] S_VB       = 4'd4;
	localparam logic [3:0] S_VC       = 4'd5;
	localparam logic [3:0] S_DIV      = 4'd6;
	localparam logic [3:0] S_MUL      = 4'd7;
	localparam logic [3:0] S_RND      = 4'd8;
	localparam logic [3:0] S_ADD      = 4'd9;
	localparam logic [3:0] S_HOLD     = 4'd10;
	localparam logic [3:0] S_HOLD_OUT = 4'd11;

	// key tables, one write port and one registered read port each
	logic [W-1:0]         time_mem_q [KEY_DEPTH];
	kls_pkg::vec_t        val_mem_q  [KEY_DEPTH];
	logic [W-1:0]         t_rd_q;
	kls_pkg::vec_t        v_rd_q;

	logic [3:0]           state_q;
	logic [kls_pkg::CFG_W-1:0] keys_in_use_q;
	logic [NW-1:0]        n_q;
	logic [AW-1:0]        idx_q;
	logic [W-1:0]         tm_q;
	logic [W-1:0]         prev_q;
	logic [W-1:0]         num_q;
	logic [W-1:0]         den_q;
	kls_pkg::vec_t        v0_q;
	logic signed [DW-1:0] d_q   [3];
	logic signed [CW-1:0] acc_q [3];
	logic [kls_pkg::Q_W-1:0] frac_q;
	logic [4:0]           mul_cnt_q;
	logic [1:0]           where_q;

	logic                 out_valid_q;
	kls_pkg::vec_t        out_v_q;
	logic [1:0]           out_where_q;
	logic [kls_pkg::SLOT_W-1:0] out_seg_q;

	logic                 in_fire;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        t_addr;
	logic [AW-1:0]        v_addr;
	logic [NW-1:0]        n_clamp;
	logic                 out_free;
	logic                 out_load;
	logic                 div_start;
	logic                 div_done;
	logic [kls_pkg::Q_W-1:0] div_quot;
	logic                 in_seg;
	logic                 walk_end;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	// a finished sample moves into the output register
	assign out_load  = ((state_q == S_ADD) || (state_q == S_HOLD_OUT)) && out_free;

	// writes beyond the table are dropped
	assign wr_en   = in_fire && (action == kls_pkg::ACT_WRITE)
		&& (int'(key_slot) < KEY_DEPTH);
	assign wr_addr = AW'(key_slot);

	// keys_in_use of 0 acts as 1, above the depth acts as the depth
	always_comb begin
		if (keys_in_use_q == '0) begin
			n_clamp = NW'(1);
		end else if (int'(keys_in_use_q) > KEY_DEPTH) begin
			n_clamp = NW'(KEY_DEPTH);
		end else begin
			n_clamp = NW'(keys_in_use_q);
		end
	end

	// time read address: key 0 while idle, key 1 from first check, then i+2 while walking, else i
	always_comb begin
		case (state_q)
			S_IDLE:  t_addr = '0;
			S_FIRST: t_addr = AW'(1);
			S_WALK:  t_addr = idx_q + AW'(2);
			default: t_addr = idx_q;
		endcase
	end

	// value read address: segment start, then its end key
	assign v_addr = (state_q == S_VB) ? idx_q + AW'(1) : idx_q;

	// segment test against the pair (prev_q, t_rd_q)
	assign in_seg   = (prev_q <= tm_q) && (tm_q <= t_rd_q);
	assign walk_end = (NW'(idx_q) + NW'(2)) >= n_q;

	assign div_start = (state_q == S_VB);

	kls_frac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// table storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem_q[wr_addr] <= key_time;
			val_mem_q[wr_addr]  <= {key_z, key_y, key_x};
		end
		t_rd_q <= time_mem_q[t_addr];
		v_rd_q <= val_mem_q[v_addr];
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_in_use_q <= kls_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			keys_in_use_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mul_cnt_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && (action == kls_pkg::ACT_SAMPLE)) begin
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					// t_rd_q holds key 0 here
					if ((n_q == NW'(1)) || (tm_q <= t_rd_q)) begin
						state_q <= S_HOLD;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (in_seg) begin
						state_q <= S_VA;
					end else if (walk_end) begin
						state_q <= S_HOLD;
					end
				end
				S_VA:  state_q <= S_VB;
				S_VB:  state_q <= S_VC;
				S_VC:  state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						mul_cnt_q <= '0;
						state_q   <= S_MUL;
					end
				end
				S_MUL: begin
					mul_cnt_q <= mul_cnt_q + 5'd1;
					if (mul_cnt_q == MUL_LAST) begin
						state_q <= S_RND;
					end
				end
				S_RND: state_q <= S_ADD;
				S_ADD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_HOLD: state_q <= S_HOLD_OUT;
				S_HOLD_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				tm_q <= sample_time;
				n_q  <= n_clamp;
			end
			S_FIRST: begin
				idx_q   <= '0;
				prev_q  <= t_rd_q;
				where_q <= kls_pkg::WHERE_FIRST;
			end
			S_WALK: begin
				if (in_seg) begin
					where_q <= kls_pkg::WHERE_SEG;
					num_q   <= tm_q - prev_q;
					den_q   <= t_rd_q - prev_q;
				end else if (walk_end) begin
					// no enclosing segment: hold the last key in use
					where_q <= kls_pkg::WHERE_LAST;
					idx_q   <= AW'(n_q - NW'(1));
				end else begin
					prev_q <= t_rd_q;
					idx_q  <= idx_q + AW'(1);
				end
			end
			S_VB: v0_q <= v_rd_q;
			S_VC: begin
				for (int c = 0; c < 3; c++) begin
					d_q[c]   <= $signed({v_rd_q[c][W-1], v_rd_q[c]})
						- $signed({v0_q[c][W-1], v0_q[c]});
					acc_q[c] <= '0;
				end
			end
			S_DIV: frac_q <= div_quot;
			S_MUL: begin
				// msb-first shift-and-add over the fraction bits
				for (int c = 0; c < 3; c++) begin
					acc_q[c] <= (acc_q[c] <<< 1)
						+ (frac_q[kls_pkg::Q_W-1] ? {{(CW-DW){d_q[c][DW-1]}}, d_q[c]}
							: CW'(0));
				end
				frac_q <= {frac_q[kls_pkg::Q_W-2:0], 1'b0};
			end
			S_RND: begin
				// round half up before the floor shift
				for (int c = 0; c < 3; c++) begin
					acc_q[c] <= acc_q[c] + CW'(1 << (kls_pkg::FRAC_W - 1));
				end
			end
			S_ADD: begin
				if (out_free) begin
					for (int c = 0; c < 3; c++) begin
						out_v_q[c] <= v0_q[c] + acc_q[c][kls_pkg::FRAC_W +: W];
					end
					out_where_q <= where_q;
					out_seg_q   <= kls_pkg::SLOT_W'(idx_q);
				end
			end
			S_HOLD_OUT: begin
				if (out_free) begin
					out_v_q     <= v_rd_q;
					out_where_q <= where_q;
					out_seg_q   <= kls_pkg::SLOT_W'(idx_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign out_x         = out_v_q[0];
	assign out_y         = out_v_q[1];
	assign out_z         = out_v_q[2];
	assign where_found   = out_where_q;
	assign segment_start = out_seg_q;

endmodule

// ----- design/kls_checker.sv -----
`include "keyframe_linear_sampler_defines.svh"

module kls_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               action,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [kls_pkg::WORD_W-1:0]  out_x,
	input logic signed [kls_pkg::WORD_W-1:0]  out_y,
	input logic signed [kls_pkg::WORD_W-1:0]  out_z,
	input logic [1:0]                         where_found,
	input logic [kls_pkg::SLOT_W-1:0]         segment_start
);

	// a stalled result beat holds its payload
	`KLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(where_found) && $stable(segment_start), "result changed while stalled")

	// only the three defined outcomes appear
	`KLS_ASSERT_NOW(a_where_code, out_valid, where_found == kls_pkg::WHERE_FIRST || where_found == kls_pkg::WHERE_SEG || where_found == kls_pkg::WHERE_LAST, "bad where_found code")

	// first key held always reports index zero
	`KLS_ASSERT_NOW(a_first_idx, out_valid && where_found == kls_pkg::WHERE_FIRST, segment_start == '0, "first-key hold with nonzero index")

	// a sample keeps the item channel closed on the following cycle
	`KLS_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && action == kls_pkg::ACT_SAMPLE, !in_ready, "ready right after a sample beat")

endmodule

bind keyframe_linear_sampler kls_checker u_kls_checker (.*);
